### rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] COMMAND_TYPE_MASK = 8'hF0;
	localparam logic [7:0] CMD_NIBBLE        = 8'h80;
	localparam logic [7:0] END_BYTE          = 8'h0A;
	localparam logic [7:0] START_BYTE_RESET  = 8'h00;
	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd130;

	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned CFG_ADDR_W = 3;

	typedef enum logic [0:0] {
		REG_START_BYTE  = 1'b0,
		REG_MAX_PAYLOAD = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		KIND_PAYLOAD = 1'b0,
		KIND_FRAME   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] command;
		logic [7:0] frame_length;
		logic       checksum_ok;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

### rtl/core/sfr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [7:0]    start_byte,
	input  wire logic [7:0]    max_payload,
	input  wire sfr_pkg::q_stat_t q_stat,
	output logic               push,
	output sfr_pkg::res_t      push_data
);

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_CMD    = 3'd1,
		PH_LEN    = 3'd2,
		PH_DATA   = 3'd3,
		PH_CRC_HI = 3'd4,
		PH_CRC_LO = 3'd5,
		PH_END    = 3'd6,
		PH_SLACK  = 3'd7
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [15:0] sum_q;
	logic [15:0] rx_sum_q;
	logic [7:0]  cmd_q;
	logic        accept;
	logic [7:0]  pos_next;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign pos_next = pos_q + 8'd1;

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		case (phase_q)
			PH_DATA: begin
				push                    = accept;
				push_data.kind          = sfr_pkg::KIND_PAYLOAD;
				push_data.payload_byte  = rx_byte;
				push_data.payload_index = pos_q;
			end
			PH_END, PH_SLACK: begin
				push                   = accept && (rx_byte == sfr_pkg::END_BYTE);
				push_data.kind         = sfr_pkg::KIND_FRAME;
				push_data.command      = cmd_q;
				push_data.frame_length = len_q;
				push_data.checksum_ok  = (sum_q == rx_sum_q);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			rx_sum_q <= '0;
			cmd_q    <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_START: begin
					if (rx_byte == start_byte) begin
						phase_q <= PH_CMD;
					end else begin
						pos_q <= '0;
					end
				end
				PH_CMD: begin
					if ((rx_byte & sfr_pkg::COMMAND_TYPE_MASK) == sfr_pkg::CMD_NIBBLE) begin
						cmd_q   <= rx_byte;
						phase_q <= PH_LEN;
					end else begin
						phase_q <= PH_START;
						pos_q   <= '0;
					end
				end
				PH_LEN: begin
					if (rx_byte <= max_payload) begin
						len_q   <= rx_byte;
						sum_q   <= '0;
						pos_q   <= '0;
						phase_q <= (rx_byte == 8'd0) ? PH_CRC_HI : PH_DATA;
					end else begin
						phase_q <= PH_START;
						pos_q   <= '0;
					end
				end
				PH_DATA: begin
					sum_q <= sum_q + {8'd0, rx_byte};
					pos_q <= pos_next;
					if (pos_next >= len_q) begin
						phase_q <= PH_CRC_HI;
					end
				end
				PH_CRC_HI: begin
					rx_sum_q <= {rx_byte, 8'd0};
					phase_q  <= PH_CRC_LO;
				end
				PH_CRC_LO: begin
					rx_sum_q <= {rx_sum_q[15:8], rx_byte};
					phase_q  <= PH_END;
				end
				PH_END: begin
					if (rx_byte == sfr_pkg::END_BYTE) begin
						phase_q <= PH_START;
						pos_q   <= '0;
					end else begin
						phase_q <= PH_SLACK;
					end
				end
				PH_SLACK: begin
					phase_q <= PH_START;
					pos_q   <= '0;
				end
				default: begin
					phase_q <= PH_START;
					pos_q   <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/sfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue #(
	parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sfr_pkg::res_t push_data,
	input  wire logic          pop,
	output sfr_pkg::res_t      pop_data,
	output sfr_pkg::q_stat_t   stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sfr_pkg::res_t  mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/sfr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sfr_pkg::q_stat_t q_stat,
	output logic                  pop,
	input  wire sfr_pkg::res_t    pop_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [sfr_pkg::OUT_DATA_W-1:0] out_data,
	output logic                  out_user
);

	logic                            valid_q;
	logic [sfr_pkg::OUT_DATA_W-1:0]  data_q;
	logic                            user_q;

	assign pop       = !q_stat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			user_q <= pop_data.kind;
			data_q <= {7'd0, pop_data.checksum_ok, pop_data.frame_length, pop_data.command,
				pop_data.payload_index, pop_data.payload_byte};
		end
	end

endmodule

`default_nettype wire

### rtl/core/serial_frame_receiver.sv
// Byte-serial frame receiver.
// Bytes enter on the s_axis channel, one per transfer. Frames are start byte,
// command byte (upper nibble 8), length byte, payload, 16-bit big-endian sum,
// line-feed end byte (one extra byte of slack before the end byte is allowed).
// Results leave on the m_axis channel: tuser 0 is a payload byte with its
// index, tuser 1 is a frame summary (command, length, checksum match).
// Registers on the APB port: 0x0 start byte, 0x4 largest payload length.
// Write them only while no frame is in flight.
// Throughput: one byte per cycle while the queue is not full. A result is
// written into a result queue at the edge that takes its byte, then moves
// into the output register when it frees up, and from there shows on m_axis.
// When m_axis stalls, results collect in the QUEUE_DEPTH-entry queue plus the
// output register; s_axis_tready drops only when the queue is full.
// Reset returns the parser to waiting for a start byte, empties the queue and
// sets the registers to start byte 0x00 and length limit 130.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver #(
	parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [7:0] payload_byte, [15:8] payload_index, [23:16] command,
	// [31:24] frame_length, [32] checksum_ok, [39:33] zero
	output logic [sfr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tuser,  // [0] kind
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic             [7:0] start_byte_q;
	logic             [7:0] max_payload_q;
	logic                   cfg_write;
	sfr_pkg::reg_idx_t      reg_idx;
	sfr_pkg::q_stat_t       q_stat;
	sfr_pkg::res_t          push_data;
	sfr_pkg::res_t          pop_data;
	logic                   push;
	logic                   pop;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = sfr_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= sfr_pkg::START_BYTE_RESET;
			max_payload_q <= sfr_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				sfr_pkg::REG_START_BYTE:  start_byte_q  <= pwdata[7:0];
				sfr_pkg::REG_MAX_PAYLOAD: max_payload_q <= pwdata[7:0];
				default: begin
					start_byte_q <= start_byte_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sfr_pkg::REG_START_BYTE:  prdata = {24'd0, start_byte_q};
			sfr_pkg::REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_q};
			default:                  prdata = '0;
		endcase
	end

	sfr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.rx_byte     (s_axis_tdata),
		.start_byte  (start_byte_q),
		.max_payload (max_payload_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("result pushed into full queue");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[39:16] == '0))
		else $error("payload result carries frame fields");

	a_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[15:0] == '0))
		else $error("frame result carries payload fields");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid)
		else $error("popped result not shown on output");

endmodule

`default_nettype wire

### dv/tb_serial_frame_receiver.sv
`timescale 1ns / 1ps

module tb_serial_frame_receiver;

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 95;

	typedef enum logic [2:0] {
		PH_WAIT_START,
		PH_COMMAND,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_SUM_HI,
		PH_SUM_LO,
		PH_END,
		PH_END_SLACK
	} parse_phase_t;

	typedef enum int {
		END_PLAIN,
		END_LATE,
		END_MISSING
	} end_style_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata = 8'h00;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [sfr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [sfr_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]                    pwdata = 32'h0;
	logic [31:0]                    prdata;
	logic                           pready;

	serial_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// [7:0] payload_byte, [15:8] payload_index, [23:16] command,
		// [31:24] frame_length, [32] checksum_ok, [39:33] zero
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),   // [0] kind
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	logic [7:0]   cfg_start_byte  = sfr_pkg::START_BYTE_RESET;
	logic [7:0]   cfg_max_payload = sfr_pkg::MAX_PAYLOAD_RESET;
	parse_phase_t rx_phase        = PH_WAIT_START;
	logic [7:0]   rx_position     = 8'h00;
	logic [7:0]   rx_declared_len = 8'h00;
	logic [15:0]  rx_sum          = 16'h0000;
	logic [15:0]  rx_checksum     = 16'h0000;
	logic [7:0]   rx_command      = 8'h00;

	sfr_pkg::res_t parsed_results [$];
	sfr_pkg::res_t got_result;
	sfr_pkg::res_t want_result;

	int  errors = 0;
	int  bytes_sent = 0;
	int  payloads_seen = 0;
	int  frames_seen = 0;
	int  settings_used = 0;
	int  idle_cycles = 0;
	bit  tx_pace = 1'b0;
	bit  rx_pace = 1'b0;
	bit  hold_request = 1'b0;

	task automatic parse_rx_byte(input logic [7:0] b);
		sfr_pkg::res_t r;
		r = '0;
		case (rx_phase)
			PH_WAIT_START: begin
				if (b == cfg_start_byte)
					rx_phase = PH_COMMAND;
			end
			PH_COMMAND: begin
				if ((b & sfr_pkg::COMMAND_TYPE_MASK) == sfr_pkg::CMD_NIBBLE) begin
					rx_command = b;
					rx_phase = PH_LENGTH;
				end else begin
					rx_phase = PH_WAIT_START;
				end
			end
			PH_LENGTH: begin
				if (b <= cfg_max_payload) begin
					rx_declared_len = b;
					rx_sum = 16'h0000;
					rx_position = 8'h00;
					rx_phase = (b == 8'h00) ? PH_SUM_HI : PH_PAYLOAD;
				end else begin
					rx_phase = PH_WAIT_START;
				end
			end
			PH_PAYLOAD: begin
				r.kind = sfr_pkg::KIND_PAYLOAD;
				r.payload_byte = b;
				r.payload_index = rx_position;
				parsed_results.push_back(r);
				rx_sum = rx_sum + {8'h00, b};
				rx_position = rx_position + 8'h01;
				if (rx_position >= rx_declared_len)
					rx_phase = PH_SUM_HI;
			end
			PH_SUM_HI: begin
				rx_checksum = {b, 8'h00};
				rx_phase = PH_SUM_LO;
			end
			PH_SUM_LO: begin
				rx_checksum[7:0] = b;
				rx_phase = PH_END;
			end
			default: begin
				if (b == sfr_pkg::END_BYTE) begin
					r.kind = sfr_pkg::KIND_FRAME;
					r.command = rx_command;
					r.frame_length = rx_declared_len;
					r.checksum_ok = (rx_sum == rx_checksum);
					parsed_results.push_back(r);
					rx_phase = PH_WAIT_START;
				end else if (rx_phase == PH_END) begin
					rx_phase = PH_END_SLACK;
				end else begin
					rx_phase = PH_WAIT_START;
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_pace ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		parse_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] command, input logic [7:0] length,
			input bit sum_good, input end_style_t style);
		logic [15:0] sum;
		logic [7:0]  p;
		sum = 16'h0000;
		send_byte(cfg_start_byte);
		send_byte(command);
		send_byte(length);
		for (int i = 0; i < length; i++) begin
			p = 8'($urandom);
			sum = sum + {8'h00, p};
			send_byte(p);
		end
		if (!sum_good)
			sum = 16'($urandom);
		send_byte(sum[15:8]);
		send_byte(sum[7:0]);
		if (style != END_PLAIN) begin
			p = 8'($urandom_range(0, 254));
			if (p >= sfr_pkg::END_BYTE)
				p = p + 8'h01;
			send_byte(p);
		end
		if (style == END_MISSING) begin
			p = 8'($urandom_range(0, 254));
			if (p >= sfr_pkg::END_BYTE)
				p = p + 8'h01;
			send_byte(p);
		end else begin
			send_byte(sfr_pkg::END_BYTE);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (parsed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input sfr_pkg::reg_idx_t idx, input logic [7:0] value);
		logic [31:0] w;
		w = $urandom;
		w[7:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == sfr_pkg::REG_START_BYTE)
			cfg_start_byte = value;
		else
			cfg_max_payload = value;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] start_value, input logic [7:0] max_value);
		drain_results();
		write_reg(sfr_pkg::REG_START_BYTE, start_value);
		write_reg(sfr_pkg::REG_MAX_PAYLOAD, max_value);
		settings_used++;
	endtask

	task automatic test_directed();
		tx_pace = 1'b0;
		rx_pace = 1'b0;
		send_byte(8'h55);
		// bad command equal to the start byte: not taken as a new start
		send_byte(cfg_start_byte);
		send_byte(cfg_start_byte);
		send_byte(cfg_start_byte);
		send_byte(sfr_pkg::CMD_NIBBLE);
		send_byte(cfg_max_payload + 8'h01);
		send_frame(8'h85, 8'h00, 1'b0, END_PLAIN);
		send_byte(cfg_start_byte);
		send_byte(8'h8F);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h33);
		send_byte(sfr_pkg::END_BYTE);
		send_frame(8'h81, 8'h00, 1'b1, END_MISSING);
	endtask

	task automatic test_config_extremes();
		tx_pace = 1'b1;
		rx_pace = 1'b1;
		apply_setting(8'hFF, 8'h00);
		send_frame(8'h80, 8'h00, 1'b1, END_PLAIN);
		send_byte(cfg_start_byte);
		send_byte(8'h80);
		send_byte(8'h01);
		apply_setting(sfr_pkg::END_BYTE, 8'hFF);
		send_frame(8'h8A, 8'hFF, 1'b1, END_PLAIN);
		send_frame(8'h8B, 8'h03, 1'b0, END_LATE);
	endtask

	task automatic test_backpressure();
		apply_setting(8'hC3, sfr_pkg::MAX_PAYLOAD_RESET);
		tx_pace = 1'b0;
		rx_pace = 1'b0;
		hold_request = 1'b1;
		send_frame(8'h84, 8'd24, 1'b1, END_PLAIN);
	endtask

	task automatic random_frame();
		int         pick;
		int         cap;
		int         n;
		int         style_pick;
		logic [7:0] b;
		logic [7:0] length;
		end_style_t style;
		tx_pace = ($urandom_range(0, 3) != 0);
		rx_pace = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 19);
		if (pick < 16) begin
			cap = (cfg_max_payload < 12) ? cfg_max_payload : 12;
			if ($urandom_range(0, 19) == 0)
				length = 8'($urandom_range(0, cfg_max_payload));
			else
				length = 8'($urandom_range(0, cap));
			style_pick = $urandom_range(0, 9);
			style = (style_pick == 0) ? END_LATE :
				(style_pick == 1) ? END_MISSING : END_PLAIN;
			b = 8'($urandom_range(0, 15));
			send_frame(sfr_pkg::CMD_NIBBLE | b, length, $urandom_range(0, 3) != 0, style);
		end else if (pick == 16) begin
			send_byte(cfg_start_byte);
			do b = 8'($urandom); while ((b & sfr_pkg::COMMAND_TYPE_MASK) == sfr_pkg::CMD_NIBBLE);
			send_byte(b);
		end else if (pick == 17 && cfg_max_payload != 8'hFF) begin
			send_byte(cfg_start_byte);
			b = 8'($urandom_range(0, 15));
			send_byte(sfr_pkg::CMD_NIBBLE | b);
			send_byte(8'($urandom_range(cfg_max_payload + 1, 255)));
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				do b = 8'($urandom); while (b == cfg_start_byte);
				send_byte(b);
			end
		end
	endtask

	task automatic test_random_traffic();
		int target;
		for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: apply_setting(8'($urandom), 8'($urandom));
				1: apply_setting(8'($urandom), 8'hFF);
				2: apply_setting(8'h00, 8'h00);
				default: apply_setting(8'($urandom), sfr_pkg::MAX_PAYLOAD_RESET);
			endcase
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) random_frame();
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_result.kind = sfr_pkg::kind_t'(m_axis_tuser);
			got_result.payload_byte = m_axis_tdata[7:0];
			got_result.payload_index = m_axis_tdata[15:8];
			got_result.command = m_axis_tdata[23:16];
			got_result.frame_length = m_axis_tdata[31:24];
			got_result.checksum_ok = m_axis_tdata[32];
			if (parsed_results.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual tuser %b tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
			end else begin
				want_result = parsed_results.pop_front();
				check_field("kind", 8'(want_result.kind), 8'(got_result.kind));
				check_field("payload_byte", want_result.payload_byte,
					got_result.payload_byte);
				check_field("payload_index", want_result.payload_index,
					got_result.payload_index);
				check_field("command", want_result.command, got_result.command);
				check_field("frame_length", want_result.frame_length,
					got_result.frame_length);
				check_field("checksum_ok", 8'(want_result.checksum_ok),
					8'(got_result.checksum_ok));
				if (want_result.kind == sfr_pkg::KIND_FRAME)
					frames_seen++;
				else
					payloads_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = rx_pace ? $urandom_range(0, 19) : 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
			while (!m_axis_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();
		drain_results();
		if (parsed_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results expected but never seen", $time,
				parsed_results.size());
		end
		$display("Sent %0d bytes under %0d register settings, with receiver hold-off.",
			bytes_sent, settings_used);
		$display("Checked %0d payload results and %0d frame results, %0d mismatches.",
			payloads_seen, frames_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
